>>> src/gcab_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package gcab_pkg;

    // Which source the output pixel comes from.
    typedef enum logic [1:0] {
        KIND_MIX,
        KIND_BACK,
        KIND_FORE
    } kind_t;

    localparam int unsigned CH_W    = 8;   // one color or alpha component
    localparam int unsigned ALPHA_W = 16;  // fixed-point alpha, 0xFF00 is opaque
    localparam int unsigned NUM_W   = 24;  // weighted color sum
    localparam int unsigned QBITS   = 8;   // quotient bits of the color divide

    localparam logic [ALPHA_W-1:0] ALPHA_ONE = 16'hFF00;
    localparam logic [CH_W-1:0]    CH_FULL   = 8'hFF;

    // Register indexes of the configuration port.
    localparam logic [2:0] REG_FORE_RED   = 3'd0;
    localparam logic [2:0] REG_FORE_GREEN = 3'd1;
    localparam logic [2:0] REG_FORE_BLUE  = 3'd2;
    localparam logic [2:0] REG_FORE_ALPHA = 3'd3;
    localparam logic [2:0] REG_BACK_RED   = 3'd4;
    localparam logic [2:0] REG_BACK_GREEN = 3'd5;
    localparam logic [2:0] REG_BACK_BLUE  = 3'd6;
    localparam logic [2:0] REG_BACK_ALPHA = 3'd7;

    // Alpha terms handed from the alpha pipeline to the color stage.
    typedef struct packed {
        kind_t               kind;
        logic [ALPHA_W-1:0]  src;
        logic [ALPHA_W-1:0]  dst;
        logic [ALPHA_W-1:0]  sum;
    } alpha_terms_t;

endpackage

`default_nettype wire

>>> src/gcab_alpha.sv
`timescale 1ns / 1ps
`default_nettype none

// Five register stages that turn coverage into source and destination alphas.
module gcab_alpha
    import gcab_pkg::*;
(
    input  wire logic               aclk,
    input  wire logic               en,
    input  wire logic [CH_W-1:0]    coverage,
    input  wire logic [CH_W-1:0]    fore_alpha,
    input  wire logic [CH_W-1:0]    back_alpha,
    output alpha_terms_t            terms
);

    // Stage 1: foreground alpha times coverage.
    logic [15:0] p_reg;
    kind_t       k1_reg;
    // Stage 2: source alpha.
    logic [ALPHA_W-1:0] src2_reg;
    kind_t              k2_reg;
    // Stage 3: background alpha times remaining opacity.
    logic [NUM_W-1:0]   x3_reg;
    logic [ALPHA_W-1:0] src3_reg;
    kind_t              k3_reg;
    // Stage 4: reciprocal estimate of x / 255.
    logic [ALPHA_W-1:0] q4_reg;
    logic [NUM_W-1:0]   x4_reg;
    logic [ALPHA_W-1:0] src4_reg;
    kind_t              k4_reg;
    // Stage 5: corrected destination alpha and the sum.
    alpha_terms_t       t5_reg;

    kind_t              k1_next;
    logic [16:0]        div255_tmp;
    logic [ALPHA_W-1:0] src2_next;
    logic [40:0]        recip_prod;
    logic [NUM_W-1:0]   resid;
    logic [ALPHA_W-1:0] dst_next;

    always_comb begin
        if (coverage == '0) begin
            k1_next = KIND_BACK;
        end else if (coverage == CH_FULL && fore_alpha == CH_FULL) begin
            k1_next = KIND_FORE;
        end else begin
            k1_next = KIND_MIX;
        end

        // p / 255, exact for p below 65535.
        div255_tmp = (17'(p_reg) + 17'(p_reg[15:8]) + 17'd1) >> 8;
        src2_next  = p_reg + div255_tmp[ALPHA_W-1:0];

        // The estimate is low by at most one.
        recip_prod = 41'(x3_reg) * 41'h10101;

        resid    = x4_reg - ((NUM_W'(q4_reg) << 8) - NUM_W'(q4_reg));
        dst_next = (resid >= NUM_W'(255)) ? q4_reg + 16'd1 : q4_reg;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            p_reg    <= 16'(fore_alpha) * 16'(coverage);
            k1_reg   <= k1_next;
            src2_reg <= src2_next;
            k2_reg   <= k1_reg;
            x3_reg   <= NUM_W'(back_alpha) * NUM_W'(ALPHA_ONE - src2_reg);
            src3_reg <= src2_reg;
            k3_reg   <= k2_reg;
            q4_reg   <= recip_prod[39:24];
            x4_reg   <= x3_reg;
            src4_reg <= src3_reg;
            k4_reg   <= k3_reg;
            t5_reg.kind <= k4_reg;
            t5_reg.src  <= src4_reg;
            t5_reg.dst  <= dst_next;
            t5_reg.sum  <= src4_reg + dst_next;
        end
    end

    assign terms = t5_reg;

endmodule

`default_nettype wire

>>> src/gcab_div.sv
`timescale 1ns / 1ps
`default_nettype none

// Restoring divider, one quotient bit per register stage. The quotient is
// known to fit in QBITS bits.
module gcab_div
    import gcab_pkg::*;
(
    input  wire logic               aclk,
    input  wire logic               en,
    input  wire logic [NUM_W-1:0]   num,
    input  wire logic [ALPHA_W-1:0] den,
    output logic      [CH_W-1:0]    quo
);

    logic [NUM_W-1:0]   rem_reg [QBITS];
    logic [ALPHA_W-1:0] den_reg [QBITS];
    logic [CH_W-1:0]    q_reg   [QBITS];

    logic [NUM_W-1:0]   rem_in  [QBITS];
    logic [ALPHA_W-1:0] den_in  [QBITS];
    logic [CH_W-1:0]    q_in    [QBITS];
    logic [NUM_W-1:0]   rem_next[QBITS];
    logic [CH_W-1:0]    q_next  [QBITS];
    logic [NUM_W-1:0]   trial   [QBITS];

    always_comb begin
        rem_in[0] = num;
        den_in[0] = den;
        q_in[0]   = '0;
        for (int k = 1; k < QBITS; k++) begin
            rem_in[k] = rem_reg[k-1];
            den_in[k] = den_reg[k-1];
            q_in[k]   = q_reg[k-1];
        end
        for (int k = 0; k < QBITS; k++) begin
            trial[k] = NUM_W'(den_in[k]) << (QBITS - 1 - k);
            if (rem_in[k] >= trial[k]) begin
                rem_next[k] = rem_in[k] - trial[k];
                q_next[k]   = q_in[k] | (CH_W'(1) << (QBITS - 1 - k));
            end else begin
                rem_next[k] = rem_in[k];
                q_next[k]   = q_in[k];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int k = 0; k < QBITS; k++) begin
                rem_reg[k] <= rem_next[k];
                den_reg[k] <= den_in[k];
                q_reg[k]   <= q_next[k];
            end
        end
    end

    assign quo = q_reg[QBITS-1];

endmodule

`default_nettype wire

>>> src/glyph_coverage_alpha_blend.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Word
// s_        in         tdata[7:0] = coverage
// m_        out        tdata[31:0] = out_red, out_green, out_blue, out_alpha
// cfg_      in         index 0..7 = fore RGBA, back RGBA; 8-bit data
//
// There are 14 register stages. The first one loads at the edge that accepts
// a word. One word can be accepted every cycle while the output is not held.
// The depth is set by five alpha stages, one color-weighting multiply stage
// and eight stages of the restoring divider.
// Reset (synchronous, aresetn low) clears every valid bit and loads the
// default colors: opaque white over transparent black.
// When the output word is held by m_tready low, the whole pipeline holds.
module glyph_coverage_alpha_blend
    import gcab_pkg::*;
(
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  wire logic [7:0]   s_tdata,   // [7:0] coverage
    output logic              m_tvalid,
    input  wire logic         m_tready,
    output logic      [31:0]  m_tdata,   // [7:0] red, [15:8] green,
                                         // [23:16] blue, [31:24] alpha
    input  wire logic         cfg_wen,
    input  wire logic [2:0]   cfg_index,
    input  wire logic [7:0]   cfg_wdata
);

    localparam int unsigned DEPTH = 6 + QBITS;

    logic [CH_W-1:0] fr_reg, fg_reg, fb_reg, fa_reg;
    logic [CH_W-1:0] br_reg, bg_reg, bb_reg, ba_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fr_reg <= 8'd255;
            fg_reg <= 8'd255;
            fb_reg <= 8'd255;
            fa_reg <= 8'd255;
            br_reg <= 8'd0;
            bg_reg <= 8'd0;
            bb_reg <= 8'd0;
            ba_reg <= 8'd0;
        end else if (cfg_wen) begin
            case (cfg_index)
                REG_FORE_RED:   fr_reg <= cfg_wdata;
                REG_FORE_GREEN: fg_reg <= cfg_wdata;
                REG_FORE_BLUE:  fb_reg <= cfg_wdata;
                REG_FORE_ALPHA: fa_reg <= cfg_wdata;
                REG_BACK_RED:   br_reg <= cfg_wdata;
                REG_BACK_GREEN: bg_reg <= cfg_wdata;
                REG_BACK_BLUE:  bb_reg <= cfg_wdata;
                REG_BACK_ALPHA: ba_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // One enable moves every stage; a bubble at the output or m_tready high lets it advance.
    logic [DEPTH-1:0] v_reg;
    logic             en;

    assign en       = !v_reg[DEPTH-1] || m_tready;
    assign s_tready = en;
    assign m_tvalid = v_reg[DEPTH-1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else if (en) begin
            v_reg <= {v_reg[DEPTH-2:0], s_tvalid};
        end
    end

    alpha_terms_t terms;

    gcab_alpha u_alpha (
        .aclk       (aclk),
        .en         (en),
        .coverage   (s_tdata),
        .fore_alpha (fa_reg),
        .back_alpha (ba_reg),
        .terms      (terms)
    );

    // Stage 6: alpha-weighted color sums, one per channel.
    logic [NUM_W-1:0]   nr_reg, ng_reg, nb_reg;
    logic [ALPHA_W-1:0] sum6_reg;
    kind_t              kind6_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            nr_reg    <= NUM_W'(fr_reg) * NUM_W'(terms.src)
                       + NUM_W'(br_reg) * NUM_W'(terms.dst);
            ng_reg    <= NUM_W'(fg_reg) * NUM_W'(terms.src)
                       + NUM_W'(bg_reg) * NUM_W'(terms.dst);
            nb_reg    <= NUM_W'(fb_reg) * NUM_W'(terms.src)
                       + NUM_W'(bb_reg) * NUM_W'(terms.dst);
            sum6_reg  <= terms.sum;
            kind6_reg <= terms.kind;
        end
    end

    logic [CH_W-1:0] qr, qg, qb;

    gcab_div u_div_red (
        .aclk (aclk), .en (en), .num (nr_reg), .den (sum6_reg), .quo (qr)
    );
    gcab_div u_div_green (
        .aclk (aclk), .en (en), .num (ng_reg), .den (sum6_reg), .quo (qg)
    );
    gcab_div u_div_blue (
        .aclk (aclk), .en (en), .num (nb_reg), .den (sum6_reg), .quo (qb)
    );

    // Side data runs alongside the divider stages.
    kind_t           kind_d_reg  [QBITS];
    logic [CH_W-1:0] alpha_d_reg [QBITS];
    logic            zero_d_reg  [QBITS];

    always_ff @(posedge aclk) begin
        if (en) begin
            kind_d_reg[0]  <= kind6_reg;
            alpha_d_reg[0] <= sum6_reg[15:8];
            zero_d_reg[0]  <= (sum6_reg == '0);
            for (int k = 1; k < QBITS; k++) begin
                kind_d_reg[k]  <= kind_d_reg[k-1];
                alpha_d_reg[k] <= alpha_d_reg[k-1];
                zero_d_reg[k]  <= zero_d_reg[k-1];
            end
        end
    end

    kind_t           kind_out;
    logic            zero_out;

    assign kind_out = kind_d_reg[QBITS-1];
    assign zero_out = zero_d_reg[QBITS-1];

    // The special cases take the configured colors directly; the user must keep
    // configuration steady while words are in flight; the block does not enforce it.
    always_comb begin
        case (kind_out)
            KIND_BACK: m_tdata = {ba_reg, bb_reg, bg_reg, br_reg};
            KIND_FORE: m_tdata = {fa_reg, fb_reg, fg_reg, fr_reg};
            KIND_MIX: begin
                if (zero_out) begin
                    m_tdata = '0;
                end else begin
                    m_tdata = {alpha_d_reg[QBITS-1], qb, qg, qr};
                end
            end
            default: m_tdata = '0;
        endcase
    end

    // Ready follows only the output stage.
    a_ready: assert property (@(posedge aclk) disable iff (aresetn !== 1'b1)
        s_tready == (!m_tvalid || m_tready))
        else $error("ready does not follow the output stage");

    // Zero coverage shows the background color unchanged.
    a_back: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && kind_out == KIND_BACK) |->
        (m_tdata == {ba_reg, bb_reg, bg_reg, br_reg}))
        else $error("background pass-through mismatch");

    // A zero summed alpha yields a transparent black word.
    a_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && kind_out == KIND_MIX && zero_out) |-> (m_tdata == '0))
        else $error("zero alpha word is not black");

endmodule

`default_nettype wire

>>> bench/glyph_coverage_alpha_blend_test.sv
`timescale 1ns / 1ps

// Bench for the glyph coverage blender. A table of directed pixels comes first,
// then random pixels under several color settings. Every result word is
// compared with a predicted pixel computed here from the register copies.
module glyph_coverage_alpha_blend_test;
    import gcab_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 30;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;
    logic        cfg_wen;
    logic [2:0]  cfg_index;
    logic [7:0]  cfg_wdata;

    glyph_coverage_alpha_blend dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_wen(cfg_wen), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
    );

    typedef struct packed {
        logic [7:0] alpha;
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
    } pixel_t;

    // Bench copy of the eight color registers, indexed by register number.
    logic [7:0] color_regs [8];

    pixel_t pending_pixels [$];
    int     error_count;
    int     idle_cycles;
    int     stall_left;    // remaining cycles of the current receiver stall
    bit     calm;          // no idling on either side in the last part of the run

    // One directed row: coverage plus, where obvious, the expected word.
    typedef struct {
        logic [7:0] coverage;
        bit         typed;
        pixel_t     want;
    } row_t;

    always begin
        aclk = 1'b1; #10;
        aclk = 1'b0; #10;
    end

    task automatic report_mismatch(input string what, input pixel_t got, input pixel_t want);
        $display("mismatch %s: got %h expected %h", what, got, want);
        error_count++;
    endtask

    function automatic logic [7:0] weigh(input logic [7:0] fc, input logic [7:0] bc,
                                         input logic [31:0] src, input logic [31:0] dst,
                                         input logic [31:0] sum);
        logic [31:0] q;
        if (sum == 0) return 8'd0;
        q = (fc * src + bc * dst) / sum;
        return q[7:0];
    endfunction

    // Source-over blend of the foreground, scaled by coverage, over the background.
    function automatic pixel_t blend_pixel(input logic [7:0] coverage);
        pixel_t      p;
        logic [31:0] src, dst, sum;
        if (coverage == 0) begin
            p = {color_regs[REG_BACK_ALPHA], color_regs[REG_BACK_BLUE],
                 color_regs[REG_BACK_GREEN], color_regs[REG_BACK_RED]};
        end else if (coverage == CH_FULL && color_regs[REG_FORE_ALPHA] == CH_FULL) begin
            p = {CH_FULL, color_regs[REG_FORE_BLUE],
                 color_regs[REG_FORE_GREEN], color_regs[REG_FORE_RED]};
        end else begin
            src = 32'(color_regs[REG_FORE_ALPHA]) * 256 * coverage / 255;
            dst = 32'(color_regs[REG_BACK_ALPHA]) * 256 * (32'(ALPHA_ONE) - src)
                  / 32'(ALPHA_ONE);
            sum = src + dst;
            p.red   = weigh(color_regs[REG_FORE_RED], color_regs[REG_BACK_RED], src, dst, sum);
            p.green = weigh(color_regs[REG_FORE_GREEN], color_regs[REG_BACK_GREEN],
                            src, dst, sum);
            p.blue  = weigh(color_regs[REG_FORE_BLUE], color_regs[REG_BACK_BLUE], src, dst, sum);
            p.alpha = 8'(sum / 256);
        end
        return p;
    endfunction

    // Receiver: random stalls, compare each word with the oldest prediction.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                if (pending_pixels.size() == 0) begin
                    report_mismatch("unexpected word", m_tdata, '0);
                end else begin
                    pixel_t want;
                    pixel_t got;
                    want = pending_pixels.pop_front();
                    got  = m_tdata;
                    if (got.red   !== want.red)   report_mismatch("red", got, want);
                    if (got.green !== want.green) report_mismatch("green", got, want);
                    if (got.blue  !== want.blue)  report_mismatch("blue", got, want);
                    if (got.alpha !== want.alpha) report_mismatch("alpha", got, want);
                end
            end
            if (calm) begin
                m_tready <= 1'b1;
            end else if (stall_left != 0) begin
                stall_left <= stall_left - 1;
                if (stall_left == 1) m_tready <= 1'b1;
            end else if ($urandom_range(0, 5) == 0) begin
                m_tready   <= 1'b0;
                stall_left <= $urandom_range(1, 3);
            end
        end
    end

    // Watchdog: any cycle without a handshake on either side counts toward the limit.
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    // Leaves the write enable high; the caller drops it after the last write.
    task automatic write_reg(input logic [2:0] index, input logic [7:0] value);
        cfg_wen   <= 1'b1;
        cfg_index <= index;
        cfg_wdata <= value;
        @(posedge aclk);
        color_regs[index] = value;
    endtask

    // Sends one word; the prediction is queued at the clock edge that accepts it.
    task automatic send_pixel(input logic [7:0] coverage);
        int gap;
        if (!calm && $urandom_range(0, 4) == 0) begin
            gap = $urandom_range(1, 3);
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= coverage;
        do @(posedge aclk); while (!s_tready);
        pending_pixels.push_back(blend_pixel(coverage));
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending_pixels.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // Random coverage leaning on the end points, where the shortcuts live.
    function automatic logic [7:0] pick_coverage();
        case ($urandom_range(0, 7))
            0: return 8'd0;
            1: return 8'hFF;
            2: return 8'(1 + $urandom_range(0, 1));
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic program_colors(input int style);
        for (int i = 0; i < 8; i++) begin
            logic [7:0] v;
            case (style)
                0: v = 8'h00;
                1: v = 8'hFF;
                default: v = 8'($urandom_range(0, 255));
            endcase
            // Opaque foreground in some random settings, so full coverage takes the shortcut.
            if (style == 2 && i == REG_FORE_ALPHA && $urandom_range(0, 2) == 0) v = CH_FULL;
            write_reg(3'(i), v);
        end
        cfg_wen <= 1'b0;
    endtask

    row_t rows [$];

    initial begin
        row_t r;
        aresetn     = 1'b0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        m_tready    = 1'b0;
        cfg_wen     = 1'b0;
        cfg_index   = '0;
        cfg_wdata   = '0;
        error_count = 0;
        idle_cycles = 0;
        calm        = 1'b0;
        // Reset colors: opaque white foreground, transparent black background.
        for (int i = 0; i < 4; i++) color_regs[i] = 8'hFF;
        for (int i = 4; i < 8; i++) color_regs[i] = 8'h00;
        repeat (5) @(posedge aclk);
        aresetn  <= 1'b1;
        m_tready <= 1'b1;
        @(posedge aclk);

        // Directed rows under the reset colors. No coverage gives transparent
        // black, full coverage gives opaque white; partial coverage over a
        // transparent background keeps the white color.
        rows = '{
            '{8'h00, 1, 32'h0000_0000},
            '{8'hFF, 1, 32'hFFFF_FFFF},
            '{8'h01, 0, 32'h0},
            '{8'h80, 0, 32'h0},
            '{8'h7F, 0, 32'h0},
            '{8'hFE, 0, 32'h0},
            '{8'h55, 0, 32'h0},
            '{8'hAA, 0, 32'h0}
        };
        foreach (rows[i]) begin
            r = rows[i];
            send_pixel(r.coverage);
            if (r.typed && pending_pixels[$] !== r.want)
                report_mismatch("directed row", pending_pixels[$], r.want);
        end
        wait_drained();

        // All registers zero: the summed alpha is zero for partial coverage.
        program_colors(0);
        foreach (rows[i]) send_pixel(rows[i].coverage);
        wait_drained();
        // All registers at full scale.
        program_colors(1);
        foreach (rows[i]) send_pixel(rows[i].coverage);
        wait_drained();

        // Random phases with fresh random colors.
        for (int phase = 0; phase < 14; phase++) begin
            program_colors(2);
            if (phase == 13) calm = 1'b1;
            for (int n = 0; n < 100; n++) send_pixel(pick_coverage());
            wait_drained();
        end

        if (error_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

>>> files.f
src/gcab_pkg.sv
src/gcab_alpha.sv
src/gcab_div.sv
src/glyph_coverage_alpha_blend.sv
bench/glyph_coverage_alpha_blend_test.sv
